>>> src/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg: shared types and constants of the reader-writer lock manager
// Request and status codes, counter widths and the per-thread store bundle.
// ----------------------------------------------------------------------------
package rwl_pkg;

   localparam int THREAD_SLOTS = 64;
   localparam int COUNT_BITS   = 16;
   localparam int TID_W        = 6;
   localparam int CMD_W        = 4;
   localparam int STATUS_W     = 3;
   localparam int WAKE_W       = 2;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [TID_W-1:0]      tid_type;
   typedef logic [CMD_W-1:0]      cmd_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [WAKE_W-1:0]     wake_type;

   localparam count_type CNT_MAX = '1;

   localparam cmd_type CMD_RD_ACQ   = 4'd0;
   localparam cmd_type CMD_WR_ACQ   = 4'd1;
   localparam cmd_type CMD_LOCKOUT  = 4'd2;
   localparam cmd_type CMD_REALLOW  = 4'd3;
   localparam cmd_type CMD_RD_REL   = 4'd4;
   localparam cmd_type CMD_WR_REL   = 4'd5;
   localparam cmd_type CMD_RETRY_RD = 4'd6;
   localparam cmd_type CMD_RETRY_WR = 4'd7;
   localparam cmd_type CMD_RETRY_UP = 4'd8;

   localparam status_type ST_GRANTED  = 3'd0;
   localparam status_type ST_WAIT     = 3'd1;
   localparam status_type ST_DEADLOCK = 3'd2;
   localparam status_type ST_DONE     = 3'd3;
   localparam status_type ST_MISUSE   = 3'd4;

   localparam wake_type WAKE_NONE    = 2'd0;
   localparam wake_type WAKE_READERS = 2'd1;
   localparam wake_type WAKE_WRITERS = 2'd2;
   localparam wake_type WAKE_UPGRADE = 2'd3;

   // write port of the per-thread read count store
   typedef struct packed {
      logic      en;
      tid_type   addr;
      count_type data;
   } store_wr_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == CNT_MAX) ? v : count_type'(v + 1'b1);
   endfunction

endpackage

>>> src/rwl_read_store.sv
// ----------------------------------------------------------------------------
// rwl_read_store: per-thread read counts
// One memory entry per thread, read registered at request accept. Valid bits
// make unwritten entries read as zero after reset; a write at the same edge
// as a read of the same thread is forwarded.
// ----------------------------------------------------------------------------
module rwl_read_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  rwl_pkg::tid_type      rd_addr,
   input  rwl_pkg::store_wr_type wr,
   output rwl_pkg::count_type    rd_count
);
   import rwl_pkg::*;

   count_type               mem [THREAD_SLOTS];
   logic [THREAD_SLOTS-1:0] valid_ff;
   count_type               rd_data_ff;
   count_type               fwd_data_ff;
   logic                    hit_ff;
   logic                    vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         hit_ff      <= wr.en && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
         vld_ff      <= valid_ff[rd_addr];
      end
   end

   assign rd_count = hit_ff ? fwd_data_ff : (vld_ff ? rd_data_ff : '0);

endmodule

>>> src/reader_writer_lock_manager.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_manager: recursive reader-writer lock
// Takes lock requests from numbered threads and answers each with a status
// and the waiter class to wake when a release frees the lock.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | cmd, thread_id, keep_readers
//   rsp     | out       | rsp_valid/rsp_stall  | status, wake_class
//
// One request per cycle sustained while rsp_stall is low; each request passes
// from the input register through the decision into the result register.
// The per-thread read count is read at accept and written back in the
// decision cycle, with forwarding between neighboring requests.
// Reset clears the lock state and the per-thread counts at once.
// A stalled result holds the decision stage; one more request is then held
// in the input register before req_stall rises.
// ----------------------------------------------------------------------------
module reader_writer_lock_manager (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rwl_pkg::cmd_type     req_cmd,
   input  rwl_pkg::tid_type     req_thread_id,
   input  logic                 req_keep_readers,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rwl_pkg::status_type  rsp_status,
   output rwl_pkg::wake_type    rsp_wake_class
);
   import rwl_pkg::*;

   // input register
   logic      s1_valid_ff;
   cmd_type   cmd_ff;
   tid_type   tid_ff;
   logic      keep_ff;

   // lock state
   logic      writer_held_ff,     writer_held_in;
   tid_type   writer_thread_ff,   writer_thread_in;
   count_type nest_level_ff,      nest_level_in;
   logic      readers_allowed_ff, readers_allowed_in;
   count_type reader_count_ff,    reader_count_in;
   count_type wait_rd_ff,         wait_rd_in;
   count_type wait_wr_ff,         wait_wr_in;
   count_type wait_up_ff,         wait_up_in;

   // result register
   logic       rsp_valid_ff;
   status_type status_ff,  status_in;
   wake_type   wake_ff,    wake_in;

   logic         accept;
   logic         adv;
   count_type    reads;
   store_wr_type store_wr;
   logic         self_writer;
   logic         lock_free;
   logic         tid_ok;
   wake_type     wake_pick;

   assign adv       = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;

   rwl_read_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_thread_id),
      .wr       (store_wr),
      .rd_count (reads)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         tid_ff  <= req_thread_id;
         keep_ff <= req_keep_readers;
      end
   end

   assign tid_ok      = int'(tid_ff) < THREAD_SLOTS;
   assign self_writer = writer_held_ff && (writer_thread_ff == tid_ff);
   assign lock_free   = !writer_held_ff && (reader_count_ff == '0);

   always_comb begin
      if (wait_up_ff != '0) begin
         wake_pick = WAKE_UPGRADE;
      end else if (wait_wr_ff != '0) begin
         wake_pick = WAKE_WRITERS;
      end else if (wait_rd_ff != '0) begin
         wake_pick = WAKE_READERS;
      end else begin
         wake_pick = WAKE_NONE;
      end
   end

   always_comb begin
      writer_held_in     = writer_held_ff;
      writer_thread_in   = writer_thread_ff;
      nest_level_in      = nest_level_ff;
      readers_allowed_in = readers_allowed_ff;
      reader_count_in    = reader_count_ff;
      wait_rd_in         = wait_rd_ff;
      wait_wr_in         = wait_wr_ff;
      wait_up_in         = wait_up_ff;
      status_in          = ST_MISUSE;
      wake_in            = WAKE_NONE;
      store_wr.en        = 1'b0;
      store_wr.addr      = tid_ff;
      store_wr.data      = sat_inc(reads);

      if (tid_ok) begin
         case (cmd_ff)
            CMD_RD_ACQ: begin
               if (self_writer) begin
                  nest_level_in = sat_inc(nest_level_ff);
                  status_in     = ST_GRANTED;
               end else if (readers_allowed_ff) begin
                  reader_count_in = sat_inc(reader_count_ff);
                  store_wr.en     = 1'b1;
                  status_in       = ST_GRANTED;
               end else begin
                  wait_rd_in = sat_inc(wait_rd_ff);
                  status_in  = ST_WAIT;
               end
            end
            CMD_WR_ACQ: begin
               if (self_writer) begin
                  nest_level_in = sat_inc(nest_level_ff);
                  status_in     = ST_GRANTED;
               end else if (lock_free) begin
                  writer_held_in     = 1'b1;
                  writer_thread_in   = tid_ff;
                  nest_level_in      = count_type'(1);
                  readers_allowed_in = keep_ff;
                  status_in          = ST_GRANTED;
               end else if (reads != '0) begin
                  status_in = ST_DEADLOCK;
               end else begin
                  wait_wr_in = sat_inc(wait_wr_ff);
                  status_in  = ST_WAIT;
               end
            end
            CMD_LOCKOUT: begin
               if (reader_count_ff == '0) begin
                  readers_allowed_in = 1'b0;
                  status_in          = ST_GRANTED;
               end else begin
                  wait_up_in = sat_inc(wait_up_ff);
                  status_in  = ST_WAIT;
               end
            end
            CMD_REALLOW: begin
               readers_allowed_in = 1'b1;
               status_in          = ST_DONE;
            end
            CMD_RD_REL, CMD_WR_REL: begin
               if (self_writer && nest_level_ff > count_type'(1)) begin
                  nest_level_in = nest_level_ff - 1'b1;
                  status_in     = ST_DONE;
               end else if (cmd_ff == CMD_RD_REL) begin
                  if (reader_count_ff != '0 && reads != '0) begin
                     reader_count_in = reader_count_ff - 1'b1;
                     store_wr.en     = 1'b1;
                     store_wr.data   = reads - 1'b1;
                     status_in       = ST_DONE;
                     // last reader out frees the lock
                     if (reader_count_ff == count_type'(1)) begin
                        wake_in = wake_pick;
                     end
                  end
               end else if (self_writer) begin
                  writer_held_in     = 1'b0;
                  nest_level_in      = '0;
                  readers_allowed_in = 1'b1;
                  wake_in            = wake_pick;
                  status_in          = ST_DONE;
               end
            end
            CMD_RETRY_RD: begin
               if (wait_rd_ff != '0) begin
                  if (readers_allowed_ff) begin
                     wait_rd_in      = wait_rd_ff - 1'b1;
                     reader_count_in = sat_inc(reader_count_ff);
                     store_wr.en     = 1'b1;
                     status_in       = ST_GRANTED;
                  end else begin
                     status_in = ST_WAIT;
                  end
               end
            end
            CMD_RETRY_WR: begin
               if (wait_wr_ff != '0) begin
                  if (lock_free) begin
                     wait_wr_in         = wait_wr_ff - 1'b1;
                     writer_held_in     = 1'b1;
                     writer_thread_in   = tid_ff;
                     nest_level_in      = count_type'(1);
                     readers_allowed_in = keep_ff;
                     status_in          = ST_GRANTED;
                  end else begin
                     status_in = ST_WAIT;
                  end
               end
            end
            CMD_RETRY_UP: begin
               if (wait_up_ff != '0) begin
                  if (reader_count_ff == '0) begin
                     wait_up_in         = wait_up_ff - 1'b1;
                     readers_allowed_in = 1'b0;
                     status_in          = ST_GRANTED;
                  end else begin
                     status_in = ST_WAIT;
                  end
               end
            end
            default: begin
               status_in = ST_MISUSE;
            end
         endcase
      end

      // drop the store write unless the item really advances
      store_wr.en = store_wr.en && adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         writer_held_ff     <= 1'b0;
         writer_thread_ff   <= '0;
         nest_level_ff      <= '0;
         readers_allowed_ff <= 1'b1;
         reader_count_ff    <= '0;
         wait_rd_ff         <= '0;
         wait_wr_ff         <= '0;
         wait_up_ff         <= '0;
      end else if (adv) begin
         writer_held_ff     <= writer_held_in;
         writer_thread_ff   <= writer_thread_in;
         nest_level_ff      <= nest_level_in;
         readers_allowed_ff <= readers_allowed_in;
         reader_count_ff    <= reader_count_in;
         wait_rd_ff         <= wait_rd_in;
         wait_wr_ff         <= wait_wr_in;
         wait_up_ff         <= wait_up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= status_in;
         wake_ff   <= wake_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_wake_class = wake_ff;

endmodule
